// ===== hdl/bbpc_pkg.sv =====
// ============================================================================
// bbpc_pkg: button bank press classifier shared definitions
// Field widths, register indexes, event codes and the event record.
// ============================================================================
package bbpc_pkg;

  localparam int unsigned RawW      = 5;   // raw_levels width
  localparam int unsigned IdxW      = 3;   // button_index width
  localparam int unsigned KindW     = 2;   // event_kind width
  localparam int unsigned CfgW      = 12;  // configuration register width
  localparam int unsigned CfgIdxW   = 2;   // configuration index width
  localparam int unsigned MaxEvents = 5;   // events kept per tick
  localparam int unsigned EvCntW    = 3;   // holds 0 .. MaxEvents
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = 3;
  localparam int unsigned FifoCntW  = 4;
  // Reads may start only while the queue holds at most this many entries.
  localparam int unsigned FifoIssueMax = FifoDepth - 4;

  localparam logic [CfgW-1:0] DebounceReset  = 12'd50;
  localparam logic [CfgW-1:0] LongPressReset = 12'd600;

  typedef enum logic [CfgIdxW-1:0] {
    RegDebounce  = 2'd0,
    RegLongPress = 2'd1
  } cfg_reg_e;

  typedef enum logic [KindW-1:0] {
    EvPress = 2'd0,
    EvClick = 2'd1,
    EvLong  = 2'd2
  } evt_kind_e;

  typedef struct packed {
    logic [IdxW-1:0] button_index;
    evt_kind_e       event_kind;
    logic            last_event;
  } evt_t;

endpackage

// ===== hdl/bbpc_in_if.sv =====
// ============================================================================
// bbpc_in_if: tick channel
// Carries one beat of raw button levels per tick.
// ============================================================================
interface bbpc_in_if;
  logic                       valid;
  logic                       ready;
  logic [bbpc_pkg::RawW-1:0]  raw_levels;

  modport source (output valid, output raw_levels, input ready);
  modport sink   (input valid, input raw_levels, output ready);
endinterface

// ===== hdl/bbpc_out_if.sv =====
// ============================================================================
// bbpc_out_if: event channel
// Carries one button event per beat.
// ============================================================================
interface bbpc_out_if;
  logic                        valid;
  logic                        ready;
  logic [bbpc_pkg::IdxW-1:0]   button_index;
  logic [bbpc_pkg::KindW-1:0]  event_kind;
  logic                        last_event;

  modport source (output valid, output button_index, output event_kind,
                  output last_event, input ready);
  modport sink   (input valid, input button_index, input event_kind,
                  input last_event, output ready);
endinterface

// ===== hdl/button_bank_press_classifier.sv =====
// ============================================================================
// button_bank_press_classifier: debounce and short/long press detection
// Per-button state lives in a small memory, updated once per tick.
// ============================================================================
// Usage:
//   in_s carries one beat per millisecond tick with the raw level of every
//   button. Each tick walks the buttons in order, one per clock while the
//   queue holds at most FifoIssueMax events: the state word is read from
//   memory, updated and written back the next cycle. A new tick is taken
//   in the cycle its predecessor reads its last button, so a new tick is
//   taken before the previous one has been updated.
//   out_s carries the press, click and long-press events of a tick in
//   button order; the final event of a tick has last_event set.
//   Events wait in an 8-entry queue; while the receiver stalls and the
//   queue fills, button reads pause and in_s.ready drops.
//   cfg_we_i writes debounce_ms (index 0) or long_press_ms (index 1);
//   write only while no tick is in flight.
//   Reset clears all button state, the queue and restores the registers
//   to 50 and 600 ticks; no clearing pass is needed.
// ============================================================================
module button_bank_press_classifier #(
  parameter int unsigned NUM_BUTTONS = 5,
  parameter int unsigned AGE_BITS    = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bbpc_in_if.sink                        in_s,
  bbpc_out_if.source                     out_s,
  input  logic                           cfg_we_i,
  input  logic [bbpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bbpc_pkg::CfgW-1:0]      cfg_wdata_i
);

  localparam int unsigned CntW  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int unsigned ExtW  = (NUM_BUTTONS > bbpc_pkg::RawW) ? NUM_BUTTONS
                                                                  : bbpc_pkg::RawW;
  localparam int unsigned CmpW  = (AGE_BITS > bbpc_pkg::CfgW) ? AGE_BITS : bbpc_pkg::CfgW;
  localparam int unsigned StW   = 3 + 2 * AGE_BITS;
  // state word layout: {last_raw, change_age, pressed, hold_age, long_done}
  localparam int unsigned LdB   = 0;
  localparam int unsigned HaLo  = 1;
  localparam int unsigned PrB   = AGE_BITS + 1;
  localparam int unsigned CaLo  = AGE_BITS + 2;
  localparam int unsigned LrB   = 2 * AGE_BITS + 2;
  localparam logic [CntW-1:0]     LastCnt = CntW'(NUM_BUTTONS - 1);
  localparam logic [AGE_BITS-1:0] AgeMax  = '1;

  // configuration registers
  logic [bbpc_pkg::CfgW-1:0] db_q, lp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_q <= bbpc_pkg::DebounceReset;
      lp_q <= bbpc_pkg::LongPressReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bbpc_pkg::RegDebounce:  db_q <= cfg_wdata_i;
        bbpc_pkg::RegLongPress: lp_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Read stage: walk the buttons of the current tick
  // ---------------------------------------------------------------------
  logic                           busy_q;
  logic [CntW-1:0]                cnt_q;
  logic [bbpc_pkg::RawW-1:0]      levels_q;
  logic [ExtW-1:0]                lv_ext;
  logic [bbpc_pkg::FifoCntW-1:0]  fifo_cnt;
  logic                           issue, a_last, in_acc;

  assign lv_ext = ExtW'(levels_q);
  assign issue  = busy_q && (fifo_cnt <= bbpc_pkg::FifoCntW'(bbpc_pkg::FifoIssueMax));
  assign a_last = (cnt_q == LastCnt);
  assign in_s.ready = !busy_q || (issue && a_last);
  assign in_acc = in_s.valid && in_s.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (issue) begin
      if (a_last) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      levels_q <= in_s.raw_levels;
    end
  end

  // ---------------------------------------------------------------------
  // Update stage
  // ---------------------------------------------------------------------
  logic            b_v_q, b_raw_q, b_last_q, b_first_q;
  logic [CntW-1:0] b_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_idx_q   <= cnt_q;
      b_raw_q   <= lv_ext[cnt_q];
      b_last_q  <= a_last;
      b_first_q <= (cnt_q == '0);
    end
  end

  logic [StW-1:0] st_rd, st_wr;

  bbpc_state_mem #(
    .Depth (NUM_BUTTONS),
    .Width (StW)
  ) u_state_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (issue),
    .rd_addr_i (cnt_q),
    .rd_data_o (st_rd),
    .wr_en_i   (b_v_q),
    .wr_addr_i (b_idx_q),
    .wr_data_i (st_wr)
  );

  logic [AGE_BITS-1:0]  ca, ha;
  logic                 lr, pr, ld, ev;
  bbpc_pkg::evt_kind_e  kind;

  always_comb begin
    ca   = st_rd[CaLo +: AGE_BITS];
    ha   = st_rd[HaLo +: AGE_BITS];
    lr   = st_rd[LrB];
    pr   = st_rd[PrB];
    ld   = st_rd[LdB];
    ev   = 1'b0;
    kind = bbpc_pkg::EvPress;
    // saturating age advance
    if (ca != AgeMax) begin
      ca = ca + 1'b1;
    end
    if (ha != AgeMax) begin
      ha = ha + 1'b1;
    end
    if (b_raw_q != lr) begin
      ca = '0;
      lr = b_raw_q;
    end
    if (CmpW'(ca) > CmpW'(db_q)) begin
      if (b_raw_q && !pr) begin
        pr   = 1'b1;
        ha   = '0;
        ld   = 1'b0;
        ev   = 1'b1;
        kind = bbpc_pkg::EvPress;
      end else if (!b_raw_q && pr) begin
        pr = 1'b0;
        if (!ld) begin
          ev   = 1'b1;
          kind = bbpc_pkg::EvClick;
        end
      end
      if (!ev && b_raw_q && pr && !ld && (CmpW'(ha) > CmpW'(lp_q))) begin
        ld   = 1'b1;
        ev   = 1'b1;
        kind = bbpc_pkg::EvLong;
      end
    end
    st_wr = {lr, ca, pr, ha, ld};
  end

  // ---------------------------------------------------------------------
  // Event staging: hold one event back until the next one or the tick end
  // tells whether it is the last of its tick.
  // ---------------------------------------------------------------------
  logic [bbpc_pkg::EvCntW-1:0] ev_cnt_q, ev_cnt_base;
  logic                        emit, close_q, pend_v_q, push;
  bbpc_pkg::evt_t              pend_q, push_data;

  assign ev_cnt_base = b_first_q ? '0 : ev_cnt_q;
  assign emit = b_v_q && ev && (ev_cnt_base < bbpc_pkg::EvCntW'(bbpc_pkg::MaxEvents));
  assign push = pend_v_q && (close_q || emit);

  always_comb begin
    push_data            = pend_q;
    push_data.last_event = close_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_cnt_q <= '0;
      close_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      close_q <= b_v_q && b_last_q;
      if (b_v_q) begin
        ev_cnt_q <= ev_cnt_base + bbpc_pkg::EvCntW'(emit);
      end
      if (emit) begin
        pend_v_q <= 1'b1;
      end else if (close_q) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pend_q.button_index <= bbpc_pkg::IdxW'(b_idx_q);
      pend_q.event_kind   <= kind;
      pend_q.last_event   <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------
  bbpc_pkg::evt_t head;
  logic           pop;

  assign pop = out_s.valid && out_s.ready;

  bbpc_evt_fifo u_evt_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .count_o     (fifo_cnt)
  );

  assign out_s.valid        = (fifo_cnt != '0);
  assign out_s.button_index = head.button_index;
  assign out_s.event_kind   = head.event_kind;
  assign out_s.last_event   = head.last_event;

endmodule

// ===== hdl/bbpc_state_mem.sv =====
// ============================================================================
// bbpc_state_mem: per-button state memory
// One write and one read port, registered read data, write-to-read bypass.
// Entries read as zero until first written after reset.
// ============================================================================
module bbpc_state_mem #(
  parameter int unsigned Depth = 5,
  parameter int unsigned Width = 27
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  rd_en_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic [Width-1:0]                      rd_data_o,
  input  logic                                  wr_en_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  logic [Width-1:0]                      wr_data_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [Width-1:0] rd_q;
  logic             rd_vld_q;
  logic             fwd;

  assign fwd = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      // on an address match, take the word being written this cycle
      rd_q <= fwd ? wr_data_i : mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= fwd || vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== hdl/bbpc_evt_fifo.sv =====
// ============================================================================
// bbpc_evt_fifo: event queue
// Small FIFO between the classifier pipeline and the event channel.
// ============================================================================
module bbpc_evt_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  bbpc_pkg::evt_t                push_data_i,
  input  logic                          pop_i,
  output bbpc_pkg::evt_t                head_o,
  output logic [bbpc_pkg::FifoCntW-1:0] count_o
);

  bbpc_pkg::evt_t                  buf_q [bbpc_pkg::FifoDepth];
  logic [bbpc_pkg::FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [bbpc_pkg::FifoCntW-1:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o  = buf_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule
